// ===== sv/mahd_pkg.sv =====
// MPEG audio header decoder: shared types, header codes, rate tables
// and reciprocal constants.
// No dependencies; used by mahd_front, mahd_back and the top level.
package mahd_pkg;

	localparam logic [1:0] VER_MPEG25 = 2'd0;
	localparam logic [1:0] VER_RSVD   = 2'd1;
	localparam logic [1:0] VER_MPEG2  = 2'd2;
	localparam logic [1:0] VER_MPEG1  = 2'd3;

	localparam logic [1:0] LAY_RSVD = 2'd0;
	localparam logic [1:0] LAY_III  = 2'd1;
	localparam logic [1:0] LAY_II   = 2'd2;
	localparam logic [1:0] LAY_I    = 2'd3;

	localparam logic [1:0] RIDX_RSVD = 2'd3;
	localparam logic [3:0] BIDX_FREE = 4'd0;
	localparam logic [3:0] BIDX_BAD  = 4'd15;
	localparam logic [10:0] SYNC_WORD = 11'h7FF;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_SYNC     = 3'd1,
		ST_BAD_VERSION = 3'd2,
		ST_BAD_LAYER   = 3'd3,
		ST_BAD_BITRATE = 3'd4,
		ST_BAD_RATE    = 3'd5
	} status_t;

	// Divisor left after pulling the power of two out of the sample rate.
	typedef enum logic [1:0] {
		DIV_1   = 2'd0,
		DIV_3   = 2'd1,
		DIV_441 = 2'd2
	} div_sel_t;

	localparam int RECIP_SHIFT = 32;
	localparam logic [31:0] RECIP_3   = 32'(((64'd1 << RECIP_SHIFT) + 64'd2) / 64'd3);
	localparam logic [31:0] RECIP_441 = 32'(((64'd1 << RECIP_SHIFT) + 64'd440) / 64'd441);

	localparam int KSCALE_W = 13;
	localparam int X_W      = 9 + KSCALE_W;
	localparam int PROD_W   = X_W + 32;

	typedef logic [8:0] br_tab_t [16];

	localparam br_tab_t BR_V1_L1 = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192,
		9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
	localparam br_tab_t BR_V1_L2 = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
	localparam br_tab_t BR_V1_L3 = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80,
		9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
	localparam br_tab_t BR_V2_L1 = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
		9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
	localparam br_tab_t BR_V2_L23 = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48,
		9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

	// Classified header, passed from the front to the back.
	typedef struct packed {
		logic [1:0]          version_code;
		logic [1:0]          layer_code;
		logic [3:0]          flag_bits;
		logic [8:0]          bitrate_kbps;
		logic [15:0]         sample_rate_hz;
		logic [1:0]          rate_index;
		logic                padding_bit;
		logic [1:0]          channel_mode;
		logic [1:0]          mode_extension;
		logic [1:0]          emphasis;
		status_t             status;
		logic [KSCALE_W-1:0] kscale;
		div_sel_t            div_sel;
		logic [2:0]          shift;
		logic                slot4;
	} rec_t;

	typedef struct packed {
		logic [1:0]  version_code;
		logic [1:0]  layer_code;
		logic [3:0]  flag_bits;
		logic [8:0]  bitrate_kbps;
		logic [15:0] sample_rate_hz;
		logic [1:0]  rate_index;
		logic        padding_bit;
		logic [1:0]  channel_mode;
		logic [1:0]  mode_extension;
		logic [1:0]  emphasis;
		logic [11:0] frame_bytes;
		status_t     status;
	} res_t;

endpackage

// ===== sv/mahd_queue.sv =====
// Small register FIFO used between front and back and at the result side.
// No dependencies. DEPTH must be a power of two, at least 2.
module mahd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== sv/mahd_front.sv =====
// Front end: splits the header word, checks sync and reserved codes,
// looks up bitrate and sample rate, and picks the length divisor terms.
// Depends on mahd_pkg.
module mahd_front (
	input  logic            [31:0] header_word,
	output mahd_pkg::rec_t         rec
);

	logic [1:0] ver;
	logic [1:0] lay;
	logic [3:0] bidx;
	logic [1:0] ridx;
	logic       fam441;

	assign ver  = header_word[20:19];
	assign lay  = header_word[18:17];
	assign bidx = header_word[15:12];
	assign ridx = header_word[11:10];

	always_comb begin
		rec = '0;
		rec.version_code   = ver;
		rec.layer_code     = lay;
		rec.flag_bits      = {header_word[2], header_word[3], header_word[8], !header_word[16]};
		rec.rate_index     = ridx;
		rec.padding_bit    = header_word[9];
		rec.channel_mode   = header_word[7:6];
		rec.mode_extension = header_word[5:4];
		rec.emphasis       = header_word[1:0];
		rec.slot4          = (lay == mahd_pkg::LAY_I);

		if (ver == mahd_pkg::VER_RSVD || lay == mahd_pkg::LAY_RSVD) begin
			rec.bitrate_kbps = '0;
		end else if (ver == mahd_pkg::VER_MPEG1) begin
			case (lay)
				mahd_pkg::LAY_I:  rec.bitrate_kbps = mahd_pkg::BR_V1_L1[bidx];
				mahd_pkg::LAY_II: rec.bitrate_kbps = mahd_pkg::BR_V1_L2[bidx];
				default:          rec.bitrate_kbps = mahd_pkg::BR_V1_L3[bidx];
			endcase
		end else if (lay == mahd_pkg::LAY_I) begin
			rec.bitrate_kbps = mahd_pkg::BR_V2_L1[bidx];
		end else begin
			rec.bitrate_kbps = mahd_pkg::BR_V2_L23[bidx];
		end

		// hz = 1000 * 2^shift * {1,3}, or 11025 * 2^shift
		case ({ver, ridx})
			{mahd_pkg::VER_MPEG1, 2'd0}: begin
				rec.sample_rate_hz = 16'd44100; rec.div_sel = mahd_pkg::DIV_441; rec.shift = 3'd2;
			end
			{mahd_pkg::VER_MPEG1, 2'd1}: begin
				rec.sample_rate_hz = 16'd48000; rec.div_sel = mahd_pkg::DIV_3; rec.shift = 3'd4;
			end
			{mahd_pkg::VER_MPEG1, 2'd2}: begin
				rec.sample_rate_hz = 16'd32000; rec.div_sel = mahd_pkg::DIV_1; rec.shift = 3'd5;
			end
			{mahd_pkg::VER_MPEG2, 2'd0}: begin
				rec.sample_rate_hz = 16'd22050; rec.div_sel = mahd_pkg::DIV_441; rec.shift = 3'd1;
			end
			{mahd_pkg::VER_MPEG2, 2'd1}: begin
				rec.sample_rate_hz = 16'd24000; rec.div_sel = mahd_pkg::DIV_3; rec.shift = 3'd3;
			end
			{mahd_pkg::VER_MPEG2, 2'd2}: begin
				rec.sample_rate_hz = 16'd16000; rec.div_sel = mahd_pkg::DIV_1; rec.shift = 3'd4;
			end
			{mahd_pkg::VER_MPEG25, 2'd0}: begin
				rec.sample_rate_hz = 16'd11025; rec.div_sel = mahd_pkg::DIV_441; rec.shift = 3'd0;
			end
			{mahd_pkg::VER_MPEG25, 2'd1}: begin
				rec.sample_rate_hz = 16'd12000; rec.div_sel = mahd_pkg::DIV_3; rec.shift = 3'd2;
			end
			{mahd_pkg::VER_MPEG25, 2'd2}: begin
				rec.sample_rate_hz = 16'd8000; rec.div_sel = mahd_pkg::DIV_1; rec.shift = 3'd3;
			end
			default: begin
				rec.sample_rate_hz = '0; rec.div_sel = mahd_pkg::DIV_1; rec.shift = 3'd0;
			end
		endcase

		// Slot factor scaled down by 25 for the 44.1k family, by 1000 otherwise
		fam441 = (rec.div_sel == mahd_pkg::DIV_441);
		if (lay == mahd_pkg::LAY_I) begin
			rec.kscale = fam441 ? 13'd480 : 13'd12;
		end else if (lay == mahd_pkg::LAY_II || ver == mahd_pkg::VER_MPEG1) begin
			rec.kscale = fam441 ? 13'd5760 : 13'd144;
		end else begin
			rec.kscale = fam441 ? 13'd2880 : 13'd72;
		end

		if (header_word[31:21] != mahd_pkg::SYNC_WORD) begin
			rec.status = mahd_pkg::ST_NO_SYNC;
		end else if (ver == mahd_pkg::VER_RSVD) begin
			rec.status = mahd_pkg::ST_BAD_VERSION;
		end else if (lay == mahd_pkg::LAY_RSVD) begin
			rec.status = mahd_pkg::ST_BAD_LAYER;
		end else if (bidx inside {mahd_pkg::BIDX_FREE, mahd_pkg::BIDX_BAD}) begin
			rec.status = mahd_pkg::ST_BAD_BITRATE;
		end else if (ridx == mahd_pkg::RIDX_RSVD) begin
			rec.status = mahd_pkg::ST_BAD_RATE;
		end else begin
			rec.status = mahd_pkg::ST_OK;
		end
	end

endmodule

// ===== sv/mahd_back.sv =====
// Back end: frame length through a two-stage multiply (kbps * slot factor,
// then reciprocal of 3 or 441), power-of-two shift, and the result queue.
// Depends on mahd_pkg and mahd_queue.
module mahd_back #(
	parameter int OUT_DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           mid_empty,
	input  mahd_pkg::rec_t mid_rec,
	output logic           mid_pop,
	input  logic           pop,
	output logic           empty,
	output mahd_pkg::res_t res
);

	localparam int CW = $clog2(OUT_DEPTH + 1);

	logic                         v_s1;
	logic                         v_s2;
	mahd_pkg::rec_t               rec_s1;
	mahd_pkg::rec_t               rec_s2;
	logic [mahd_pkg::X_W-1:0]     x_s1;
	logic [mahd_pkg::X_W-1:0]     x_s2;
	logic [mahd_pkg::PROD_W-1:0]  prod_s2;
	logic [31:0]                  recip;
	logic [mahd_pkg::X_W-1:0]     quot;
	logic [mahd_pkg::X_W-1:0]     slots;
	logic [11:0]                  base;
	mahd_pkg::res_t               res_d;
	logic [CW-1:0]                out_count;
	logic                         out_full;
	logic [CW:0]                  committed;
	logic [$bits(mahd_pkg::res_t)-1:0] out_rdata;

	// Reserve a result slot for every beat still in the multiply stages.
	assign committed = (CW+1)'(out_count) + (CW+1)'(v_s1) + (CW+1)'(v_s2);
	assign mid_pop   = !mid_empty && !out_full && (committed < (CW+1)'(OUT_DEPTH));

	always_comb begin
		case (rec_s1.div_sel)
			mahd_pkg::DIV_3:   recip = mahd_pkg::RECIP_3;
			mahd_pkg::DIV_441: recip = mahd_pkg::RECIP_441;
			default:           recip = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= mid_pop;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mid_pop) begin
			rec_s1 <= mid_rec;
			x_s1   <= mahd_pkg::X_W'(mid_rec.bitrate_kbps) * mahd_pkg::X_W'(mid_rec.kscale);
		end
		if (v_s1) begin
			rec_s2  <= rec_s1;
			x_s2    <= x_s1;
			prod_s2 <= mahd_pkg::PROD_W'(x_s1) * mahd_pkg::PROD_W'(recip);
		end
	end

	always_comb begin
		quot = (rec_s2.div_sel == mahd_pkg::DIV_1) ? x_s2
			: prod_s2[mahd_pkg::RECIP_SHIFT +: mahd_pkg::X_W];
		slots = quot >> rec_s2.shift;
		base  = slots[11:0] + 12'(rec_s2.padding_bit);

		res_d.version_code   = rec_s2.version_code;
		res_d.layer_code     = rec_s2.layer_code;
		res_d.flag_bits      = rec_s2.flag_bits;
		res_d.bitrate_kbps   = rec_s2.bitrate_kbps;
		res_d.sample_rate_hz = rec_s2.sample_rate_hz;
		res_d.rate_index     = rec_s2.rate_index;
		res_d.padding_bit    = rec_s2.padding_bit;
		res_d.channel_mode   = rec_s2.channel_mode;
		res_d.mode_extension = rec_s2.mode_extension;
		res_d.emphasis       = rec_s2.emphasis;
		res_d.status         = rec_s2.status;
		if (rec_s2.status != mahd_pkg::ST_OK) begin
			res_d.frame_bytes = '0;
		end else if (rec_s2.slot4) begin
			res_d.frame_bytes = {base[9:0], 2'b00};
		end else begin
			res_d.frame_bytes = base;
		end
	end

	mahd_queue #(
		.WIDTH ($bits(mahd_pkg::res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (v_s2),
		.wdata  (res_d),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty),
		.count  (out_count)
	);

	assign res = mahd_pkg::res_t'(out_rdata);

endmodule

// ===== sv/mpeg_audio_header_decoder_top.sv =====
// MPEG audio frame header decoder. One header word per clock is accepted while
// full is low, and one result per clock is delivered while pop is held and empty
// is low; a header passes the mid queue, the two multiplier stages of the length
// path (kbps times slot factor, then a reciprocal of 3 or 441) and an output queue
// of OUT_DEPTH entries that holds a slot for every beat in flight; with pop held
// low the block takes MID_DEPTH + OUT_DEPTH headers before full rises.
// Depends on mahd_pkg, mahd_queue, mahd_front and mahd_back.
module mpeg_audio_header_decoder_top #(
	parameter int MID_DEPTH = 2,
	parameter int OUT_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [31:0] header_word,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output logic [1:0]  version_code,
	output logic [1:0]  layer_code,
	output logic [3:0]  flag_bits,
	output logic [8:0]  bitrate_kbps,
	output logic [15:0] sample_rate_hz,
	output logic [1:0]  rate_index,
	output logic        padding_bit,
	output logic [1:0]  channel_mode,
	output logic [1:0]  mode_extension,
	output logic [1:0]  emphasis,
	output logic [11:0] frame_bytes,
	output logic [2:0]  status
);

	localparam int MID_CW = $clog2(MID_DEPTH + 1);

	mahd_pkg::rec_t front_rec;
	mahd_pkg::rec_t mid_rec;
	mahd_pkg::res_t res;
	logic           mid_empty;
	logic           mid_pop;
	logic [MID_CW-1:0] mid_count;
	logic [$bits(mahd_pkg::rec_t)-1:0] mid_rdata;

	mahd_front u_front (
		.header_word (header_word),
		.rec         (front_rec)
	);

	mahd_queue #(
		.WIDTH ($bits(mahd_pkg::rec_t)),
		.DEPTH (MID_DEPTH)
	) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_rec),
		.full   (full),
		.pop    (mid_pop),
		.rdata  (mid_rdata),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	assign mid_rec = mahd_pkg::rec_t'(mid_rdata);

	mahd_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_rec   (mid_rec),
		.mid_pop   (mid_pop),
		.pop       (pop),
		.empty     (empty),
		.res       (res)
	);

	assign version_code   = res.version_code;
	assign layer_code     = res.layer_code;
	assign flag_bits      = res.flag_bits;
	assign bitrate_kbps   = res.bitrate_kbps;
	assign sample_rate_hz = res.sample_rate_hz;
	assign rate_index     = res.rate_index;
	assign padding_bit    = res.padding_bit;
	assign channel_mode   = res.channel_mode;
	assign mode_extension = res.mode_extension;
	assign emphasis       = res.emphasis;
	assign frame_bytes    = res.frame_bytes;
	assign status         = res.status;

	a_mid_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("back took a beat from an empty mid queue");

	a_mid_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		mid_count <= MID_CW'(MID_DEPTH))
		else $error("mid queue count past its depth");

	a_bad_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != mahd_pkg::ST_OK) |-> (frame_bytes == '0))
		else $error("invalid header carries a frame length");

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == mahd_pkg::ST_OK)
			|-> (frame_bytes != '0 && bitrate_kbps != '0 && sample_rate_hz != '0))
		else $error("valid header with zero length, bitrate or sample rate");

endmodule
